// ===== rtl/i64div_pkg.sv =====
package i64div_pkg;

  // Width of the dividend, divisor, quotient and remainder fields on the ports.
  localparam int FIELD_W = 64;

  // Width of the arithmetic; operands take the low DATA_WIDTH bits of each field.
  localparam int DATA_WIDTH = 64;

  // Iteration counter width.
  localparam int CNT_W = (DATA_WIDTH > 1) ? $clog2(DATA_WIDTH) : 1;

  // Packed stream widths, padded to whole bytes.
  localparam int TDATA_W = ((2 * FIELD_W + 7) / 8) * 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ABS_N,
    ST_ABS_D,
    ST_DIV,
    ST_FIX_Q,
    ST_FIX_R,
    ST_DONE
  } div_state_t;

  // Status from the iterative core back to the sequencer.
  typedef struct packed {
    logic busy;
    logic done;
  } div_stat_t;

endpackage

// ===== rtl/int64_divider_signed_unsigned.sv =====
// 64-bit integer divider, unsigned or signed two's complement.
//
// Input channel (in_*): one beat carries dividend and divisor in in_tdata and
// the mode in in_tuser (0 unsigned, 1 signed). Output channel (out_*): one beat
// per input beat with quotient and remainder in out_tdata and the
// divide-by-zero flag in out_tuser.
//
// Signed mode works on magnitudes; the quotient is negated when the operand
// signs differ and the remainder takes the dividend's sign. The most negative
// value divided by -1 wraps. A zero divisor returns zero quotient and remainder
// with the flag set.
//
// From the input beat to out_tvalid, an item passes through operand magnitude
// (ST_ABS_N, ST_ABS_D), 64 one-bit steps of the shift-subtract core, handoff,
// sign fix (ST_FIX_Q, ST_FIX_R) and the output load; a zero divisor goes
// straight to the output load. One item is in work at a time; the next is
// accepted once the last is loaded. in_tready is high while the sequencer is idle.
// A finished result sits in the output register; a stalled receiver does not
// stop the next item from being accepted and divided, only its final load.
// Reset (rst_n low, synchronous) empties the output register and idles.
module int64_divider_signed_unsigned (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [i64div_pkg::TDATA_W-1:0] in_tdata,   // [63:0] dividend, [127:64] divisor
  input  logic                           in_tuser,   // [0] mode
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [i64div_pkg::TDATA_W-1:0] out_tdata,  // [63:0] quotient, [127:64] remainder
  output logic                           out_tuser   // [0] divide_by_zero
);
  import i64div_pkg::*;

  div_state_t state_r, state_nxt;

  // operand / result working registers, shared across phases
  logic [DATA_WIDTH-1:0] opa_r, opa_nxt;
  logic [DATA_WIDTH-1:0] opb_r, opb_nxt;
  logic                  n_neg_r, n_neg_nxt;
  logic                  d_neg_r, d_neg_nxt;
  logic                  dz_r, dz_nxt;

  // output register
  logic                  out_valid_r, out_valid_nxt;
  logic [FIELD_W-1:0]    q_out_r, q_out_nxt;
  logic [FIELD_W-1:0]    r_out_r, r_out_nxt;
  logic                  dz_out_r, dz_out_nxt;

  logic [DATA_WIDTH-1:0] in_dividend;
  logic [DATA_WIDTH-1:0] in_divisor;
  logic [DATA_WIDTH-1:0] neg_src;
  logic [DATA_WIDTH-1:0] neg_res;

  logic                  core_start;
  div_stat_t             core_stat;
  logic [DATA_WIDTH-1:0] core_quo;
  logic [DATA_WIDTH-1:0] core_rem;

  assign in_dividend = in_tdata[DATA_WIDTH-1:0];
  assign in_divisor  = in_tdata[FIELD_W+DATA_WIDTH-1:FIELD_W];

  // single shared negator
  assign neg_src = (state_r == ST_ABS_N || state_r == ST_FIX_Q) ? opa_r : opb_r;
  assign neg_res = '0 - neg_src;

  always_comb begin
    state_nxt     = state_r;
    opa_nxt       = opa_r;
    opb_nxt       = opb_r;
    n_neg_nxt     = n_neg_r;
    d_neg_nxt     = d_neg_r;
    dz_nxt        = dz_r;
    out_valid_nxt = out_valid_r & ~out_tready;
    q_out_nxt     = q_out_r;
    r_out_nxt     = r_out_r;
    dz_out_nxt    = dz_out_r;
    in_tready     = 1'b0;
    core_start    = 1'b0;

    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          n_neg_nxt = in_tuser & in_dividend[DATA_WIDTH-1];
          d_neg_nxt = in_tuser & in_divisor[DATA_WIDTH-1];
          dz_nxt    = (in_divisor == '0);
          if (in_divisor == '0) begin
            opa_nxt   = '0;
            opb_nxt   = '0;
            state_nxt = ST_DONE;
          end else begin
            opa_nxt   = in_dividend;
            opb_nxt   = in_divisor;
            state_nxt = ST_ABS_N;
          end
        end
      end
      ST_ABS_N: begin
        if (n_neg_r) opa_nxt = neg_res;
        state_nxt = ST_ABS_D;
      end
      ST_ABS_D: begin
        if (d_neg_r) opb_nxt = neg_res;
        core_start = 1'b1;
        state_nxt  = ST_DIV;
      end
      ST_DIV: begin
        if (core_stat.done) begin
          opa_nxt   = core_quo;
          opb_nxt   = core_rem;
          state_nxt = ST_FIX_Q;
        end
      end
      ST_FIX_Q: begin
        if (n_neg_r ^ d_neg_r) opa_nxt = neg_res;
        state_nxt = ST_FIX_R;
      end
      ST_FIX_R: begin
        if (n_neg_r) opb_nxt = neg_res;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          q_out_nxt     = FIELD_W'(opa_r);
          r_out_nxt     = FIELD_W'(opb_r);
          dz_out_nxt    = dz_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    opa_r    <= opa_nxt;
    opb_r    <= opb_nxt;
    n_neg_r  <= n_neg_nxt;
    d_neg_r  <= d_neg_nxt;
    dz_r     <= dz_nxt;
    q_out_r  <= q_out_nxt;
    r_out_r  <= r_out_nxt;
    dz_out_r <= dz_out_nxt;
  end

  // operands go in at the cycle the divisor magnitude is formed
  i64div_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .start_i    (core_start),
    .dividend_i (opa_r),
    .divisor_i  (opb_nxt),
    .stat_o     (core_stat),
    .quo_o      (core_quo),
    .rem_o      (core_rem)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'({r_out_r, q_out_r});
  assign out_tuser  = dz_out_r;

  a_idle_core_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    in_tready |-> !core_stat.busy)
    else $error("core busy while sequencer idle");

  a_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    core_stat.done |-> state_r == ST_DIV)
    else $error("core finished outside the divide phase");

  a_dz_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && dz_out_r) |-> (q_out_r == '0 && r_out_r == '0))
    else $error("divide by zero with nonzero result");

  a_start_from_abs: assert property (@(posedge clk) disable iff (!rst_n)
    core_start |=> state_r == ST_DIV && core_stat.busy)
    else $error("core run not started");

endmodule

// ===== rtl/i64div_core.sv =====
module i64div_core (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             start_i,
  input  logic [i64div_pkg::DATA_WIDTH-1:0] dividend_i,
  input  logic [i64div_pkg::DATA_WIDTH-1:0] divisor_i,
  output i64div_pkg::div_stat_t            stat_o,
  output logic [i64div_pkg::DATA_WIDTH-1:0] quo_o,
  output logic [i64div_pkg::DATA_WIDTH-1:0] rem_o
);
  import i64div_pkg::*;

  // quo_r starts as the dividend; its top bit shifts into the partial
  // remainder each step while the new quotient bit shifts in at the bottom.
  logic [DATA_WIDTH-1:0] acc_r, acc_nxt;
  logic [DATA_WIDTH-1:0] quo_r, quo_nxt;
  logic [DATA_WIDTH-1:0] den_r, den_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  div_stat_t             stat_r, stat_nxt;

  logic [DATA_WIDTH-1:0] shifted;
  logic [DATA_WIDTH:0]   diff;
  logic                  take;

  always_comb begin
    shifted  = {acc_r[DATA_WIDTH-2:0], quo_r[DATA_WIDTH-1]};
    diff     = {1'b0, shifted} - {1'b0, den_r};
    // carry out of the shift means the partial remainder exceeds the divisor
    take     = acc_r[DATA_WIDTH-1] | ~diff[DATA_WIDTH];

    acc_nxt  = acc_r;
    quo_nxt  = quo_r;
    den_nxt  = den_r;
    cnt_nxt  = cnt_r;
    stat_nxt = '{busy: stat_r.busy, done: 1'b0};

    if (start_i) begin
      acc_nxt       = '0;
      quo_nxt       = dividend_i;
      den_nxt       = divisor_i;
      cnt_nxt       = CNT_W'(DATA_WIDTH - 1);
      stat_nxt.busy = 1'b1;
    end else if (stat_r.busy) begin
      acc_nxt = take ? diff[DATA_WIDTH-1:0] : shifted;
      quo_nxt = {quo_r[DATA_WIDTH-2:0], take};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == '0) begin
        stat_nxt.busy = 1'b0;
        stat_nxt.done = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stat_r <= '0;
      cnt_r  <= '0;
    end else begin
      stat_r <= stat_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    quo_r <= quo_nxt;
    den_r <= den_nxt;
  end

  assign stat_o = stat_r;
  assign quo_o  = quo_r;
  assign rem_o  = acc_r;

  a_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    start_i |-> !stat_r.busy)
    else $error("core restarted while busy");

  a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
    stat_r.done |-> $past(stat_r.busy))
    else $error("core done without a run");

endmodule

// ===== test/int64_divider_signed_unsigned_tb.sv =====
// Divider testbench: directed corner operands, then random traffic in four
// handshake phases. Each accepted input beat is divided by a bit-serial
// restoring predictor and the expected result is queued. Each output beat is
// checked against the head of that queue, field by field.
module int64_divider_signed_unsigned_tb;
  import i64div_pkg::*;

  // Operand width of the arithmetic and the mask that trims fields to it.
  localparam int DW = DATA_WIDTH;
  localparam logic [63:0] DW_MASK = {64{1'b1}} >> (64 - DW);
  localparam logic [63:0] DW_MIN  = 64'd1 << (DW - 1);

  // Codes carried in in_tuser.
  localparam logic MODE_UNSIGNED = 1'b0;
  localparam logic MODE_SIGNED   = 1'b1;

  // Cycles without any beat before the run is declared hung. The slowest item's
  // work plus a long gap on either side still leaves margin under this limit.
  localparam int HANG_LIMIT = 3000;
  // Tail wait after the last expected beat, about one item's latency.
  localparam int DRAIN_CYCLES = 80;
  localparam int MAX_REPORTS  = 10;

  typedef struct packed {
    logic [63:0] quotient;
    logic [63:0] remainder;
    logic        div_by_zero;
  } div_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [TDATA_W-1:0]     in_tdata = '0;    // [63:0] dividend, [127:64] divisor
  logic                   in_tuser = 1'b0;  // [0] mode
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [TDATA_W-1:0]     out_tdata;        // [63:0] quotient, [127:64] remainder
  logic                   out_tuser;        // [0] divide_by_zero

  div_result_t pending_results[$];
  div_result_t oldest_result;
  int          sender_idle_pct = 0;
  int          receiver_stall_pct = 0;
  int          mismatches = 0;
  int          quiet_cycles = 0;

  int64_divider_signed_unsigned u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Restoring shift-subtract division on magnitudes, one quotient bit per step.
  // Signed mode negates the quotient on differing signs; the remainder follows
  // the dividend. A zero divisor short-circuits to zeros plus the flag.
  function automatic div_result_t compute_division(input logic [63:0] dividend,
                                                   input logic [63:0] divisor,
                                                   input logic        mode);
    logic [63:0] num, den, acc, quo;
    logic        num_neg, den_neg, carry;
    div_result_t res;
    num = dividend & DW_MASK;
    den = divisor & DW_MASK;
    res = '0;
    if (den == 64'd0) begin
      res.div_by_zero = 1'b1;
      return res;
    end
    num_neg = (mode == MODE_SIGNED) && num[DW-1];
    den_neg = (mode == MODE_SIGNED) && den[DW-1];
    if (num_neg) num = (64'd0 - num) & DW_MASK;
    if (den_neg) den = (64'd0 - den) & DW_MASK;
    acc = '0;
    quo = '0;
    for (int i = DW - 1; i >= 0; i--) begin
      // bit shifted out of the partial remainder means it already exceeds den
      carry = acc[DW-1];
      acc = ((acc << 1) | {63'd0, num[i]}) & DW_MASK;
      quo = (quo << 1) & DW_MASK;
      if (carry || acc >= den) begin
        acc = (acc - den) & DW_MASK;
        quo[0] = 1'b1;
      end
    end
    if (num_neg != den_neg) quo = (64'd0 - quo) & DW_MASK;
    if (num_neg) acc = (64'd0 - acc) & DW_MASK;
    res.quotient  = quo;
    res.remainder = acc;
    return res;
  endfunction

  // Drive one input beat at the falling edge, with a random gap first, and
  // hold it until the rising edge that accepts it.
  task automatic send_division(input logic [63:0] dividend, input logic [63:0] divisor,
                               input logic mode);
    @(negedge clk);
    while ($urandom_range(0, 99) < sender_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {divisor, dividend};
    in_tuser  <= mode;
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(compute_division(dividend, divisor, mode));
  endtask

  // Operand drawn from a mix of classes so that quotients of every length and
  // both signs show up, not just the 0 or 1 that full-width pairs give.
  function automatic logic [63:0] random_operand();
    logic [63:0] val;
    val = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: ;
      1: val = val >> $urandom_range(0, 63);
      2: val = 64'd0 - (val >> $urandom_range(0, 63));
      default: begin
        case ($urandom_range(0, 5))
          0: val = 64'd0;
          1: val = 64'd1;
          2: val = {64{1'b1}};
          3: val = DW_MIN;
          4: val = DW_MIN - 64'd1;
          default: val = DW_MIN + 64'd1;
        endcase
      end
    endcase
    return val;
  endfunction

  // Unsigned corners: all-ones and zero operands, divide by one, top bit set.
  task automatic test_unsigned_edges();
    send_division(64'd0, 64'd1, MODE_UNSIGNED);
    send_division({64{1'b1}}, 64'd1, MODE_UNSIGNED);
    send_division({64{1'b1}}, {64{1'b1}}, MODE_UNSIGNED);
    send_division(64'd1, {64{1'b1}}, MODE_UNSIGNED);
    send_division({64{1'b1}}, 64'd2, MODE_UNSIGNED);
    send_division(64'd7, 64'd2, MODE_UNSIGNED);
    send_division(DW_MIN, {64{1'b1}}, MODE_UNSIGNED);
    send_division(64'h0123_4567_89ab_cdef, 64'h0000_0000_0001_0003, MODE_UNSIGNED);
  endtask

  // Signed corners: every sign combination, the most negative value, and the
  // most negative value by minus one, which wraps.
  task automatic test_signed_edges();
    send_division(64'd7, 64'd2, MODE_SIGNED);
    send_division(-64'sd7, 64'd2, MODE_SIGNED);
    send_division(64'd7, -64'sd2, MODE_SIGNED);
    send_division(-64'sd7, -64'sd2, MODE_SIGNED);
    send_division(DW_MIN, {64{1'b1}}, MODE_SIGNED);
    send_division(DW_MIN, 64'd1, MODE_SIGNED);
    send_division(DW_MIN, DW_MIN, MODE_SIGNED);
    send_division(DW_MIN - 64'd1, {64{1'b1}}, MODE_SIGNED);
    send_division({64{1'b1}}, DW_MIN, MODE_SIGNED);
    send_division(64'd0, {64{1'b1}}, MODE_SIGNED);
  endtask

  // Zero divisor in both modes, with zero and non-zero dividends.
  task automatic test_divide_by_zero();
    send_division(64'd0, 64'd0, MODE_UNSIGNED);
    send_division({64{1'b1}}, 64'd0, MODE_UNSIGNED);
    send_division(DW_MIN, 64'd0, MODE_SIGNED);
    send_division(64'd12345, 64'd0, MODE_SIGNED);
  endtask

  task automatic test_random_traffic(input int idle_pct, input int stall_pct,
                                     input int count);
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    repeat (count) begin
      send_division(random_operand(), random_operand(),
                    $urandom_range(0, 1) ? MODE_SIGNED : MODE_UNSIGNED);
    end
  endtask

  // Receiver backpressure, re-rolled every falling edge.
  always @(negedge clk) begin
    out_tready <= ($urandom_range(0, 99) >= receiver_stall_pct);
  end

  // Output checker: every beat against the oldest expectation.
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected output beat: q=%h r=%h dbz=%b",
                   out_tdata[63:0], out_tdata[127:64], out_tuser);
      end else begin
        oldest_result = pending_results.pop_front();
        if (out_tdata[63:0] !== oldest_result.quotient ||
            out_tdata[127:64] !== oldest_result.remainder ||
            out_tuser !== oldest_result.div_by_zero) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: q exp %h got %h, r exp %h got %h, dbz exp %b got %b",
                     oldest_result.quotient, out_tdata[63:0],
                     oldest_result.remainder, out_tdata[127:64],
                     oldest_result.div_by_zero, out_tuser);
        end
      end
    end
  end

  // Hang detection: count cycles with no beat on either channel.
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= HANG_LIMIT);
    $display("status: fail");
    $finish;
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_unsigned_edges();
    test_signed_edges();
    test_divide_by_zero();
    test_random_traffic(0, 0, 115);
    test_random_traffic(88, 0, 110);
    test_random_traffic(0, 88, 110);
    test_random_traffic(25, 25, 115);

    @(negedge clk);
    in_tvalid <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/i64div_pkg.sv
rtl/i64div_core.sv
rtl/int64_divider_signed_unsigned.sv
test/int64_divider_signed_unsigned_tb.sv
